@@ src/qshc_pkg.sv @@
`default_nettype none
package qshc_pkg;

  // board geometry
  localparam int MAX_SIZE = 64;
  localparam int DIAGS    = 2 * MAX_SIZE - 1;

  // request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] row_index;
    logic [5:0] column_value;
  } in_item_t;

  typedef struct packed {
    logic [11:0] conflicts;
    logic [11:0] step_count;
    logic        solved;
    logic [5:0]  read_column;
  } out_item_t;

endpackage
`default_nettype wire

@@ src/queens_swap_hill_climber.sv @@
`default_nettype none
// channel   valid      stall       payload
// -------   ---------  ----------  -----------------------------
// input     in_valid   in_stall    in_data  (qshc_pkg::in_item_t)
// output    out_valid  out_stall   out_data (qshc_pkg::out_item_t)
// config    cfg_we     -           cfg_data (board_size, 7 bits)
//
// load and unknown requests are answered straight from idle; a read passes through S_READ.
// start: clear every diagonal count (S_CLR), count each row's queen (S_SR, S_SC, S_SI), then
// per step score every row pair (S_P0..S_P5, plus S_LA, S_LB per new first row) and swap (S_U0, S_U1, S_W0, S_W1);
// all diagonal count traffic goes through one read port per count memory.
// rst is synchronous; in_stall is high from start until the result is out.
// one result register; a new item is taken once it is free or being taken.
module queens_swap_hill_climber (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [6:0]           cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire qshc_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output qshc_pkg::out_item_t       out_data
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_READ = 5'd1;
  localparam logic [4:0] S_CLR  = 5'd2;
  localparam logic [4:0] S_SR   = 5'd3;
  localparam logic [4:0] S_SC   = 5'd4;
  localparam logic [4:0] S_SI   = 5'd5;
  localparam logic [4:0] S_LA   = 5'd6;
  localparam logic [4:0] S_LB   = 5'd7;
  localparam logic [4:0] S_P0   = 5'd8;
  localparam logic [4:0] S_P1   = 5'd9;
  localparam logic [4:0] S_P2   = 5'd10;
  localparam logic [4:0] S_P3   = 5'd11;
  localparam logic [4:0] S_P4   = 5'd12;
  localparam logic [4:0] S_P5   = 5'd13;
  localparam logic [4:0] S_U0   = 5'd14;
  localparam logic [4:0] S_U1   = 5'd15;
  localparam logic [4:0] S_W0   = 5'd16;
  localparam logic [4:0] S_W1   = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;

  localparam logic [6:0] LAST_DIAG = 7'(qshc_pkg::DIAGS - 1);
  localparam logic [6:0] MAX_N     = 7'(qshc_pkg::MAX_SIZE);

  logic [4:0]  state;
  logic [6:0]  board_size;
  logic [6:0]  n;
  logic [6:0]  i, j, k;
  logic [5:0]  a, b, ba, bb;
  logic [6:0]  bi, bj;
  logic [1:0]  op;
  logic        found;
  logic signed [12:0] h, base, delta;
  logic [11:0] steps;

  // memories
  logic [5:0] qmem [qshc_pkg::MAX_SIZE];
  logic [6:0] rmem [qshc_pkg::DIAGS];
  logic [6:0] fmem [qshc_pkg::DIAGS];
  logic [5:0] q_rdata;
  logic [6:0] r_rdata, f_rdata;
  logic [6:0] r_addr_q, f_addr_q;

  logic       q_we;
  logic [5:0] q_waddr, q_wdata, q_raddr;
  logic       c_we;
  logic [6:0] r_waddr, f_waddr, r_wdata, f_wdata;
  logic       c_rd;
  logic [6:0] rsel;
  logic [5:0] csel;
  logic [6:0] r_raddr, f_raddr;
  logic [5:0] sat;
  logic [7:0] rise_full, fall_full;
  logic [12:0] rf_sum;
  logic signed [12:0] v;
  logic       accept;
  logic       out_set;
  logic [6:0] n_eff;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign n_eff = (board_size > MAX_N) ? MAX_N : board_size;
  assign sat = ({1'b0, q_rdata} > (n - 7'd1)) ? 6'(n - 7'd1) : q_rdata;
  assign rf_sum = 13'(r_rdata) + 13'(f_rdata);
  assign v = base + delta - $signed(rf_sum);

  // a result is ready: load or unknown requests, read data or end of climb
  assign out_set = (state == S_READ) || (state == S_DONE) ||
                   ((state == S_IDLE) && accept &&
                    (in_data.req_type != qshc_pkg::REQ_START) &&
                    (in_data.req_type != qshc_pkg::REQ_READ));

  // diagonal addresses of the queen under consideration
  assign rise_full = {1'b0, n} - 8'd1 + {1'b0, rsel} - {2'b0, csel};
  assign fall_full = {1'b0, rsel} + {2'b0, csel};
  assign r_raddr = rise_full[6:0];
  assign f_raddr = fall_full[6:0];

  // address and write selection
  always_comb begin
    q_we = 1'b0;
    q_waddr = i[5:0];
    q_wdata = sat;
    q_raddr = i[5:0];
    c_we = 1'b0;
    c_rd = 1'b0;
    r_waddr = r_addr_q;
    f_waddr = f_addr_q;
    r_wdata = r_rdata + 7'd1;
    f_wdata = f_rdata + 7'd1;
    rsel = i;
    csel = a;
    unique case (state)
      S_IDLE: begin
        q_raddr = in_data.row_index;
        q_waddr = in_data.row_index;
        q_wdata = in_data.column_value;
        q_we = accept && (in_data.req_type == qshc_pkg::REQ_LOAD);
      end
      S_CLR: begin
        c_we = 1'b1;
        r_waddr = k;
        f_waddr = k;
        r_wdata = '0;
        f_wdata = '0;
      end
      S_SC: begin
        q_we = 1'b1;
        csel = sat;
        c_rd = 1'b1;
      end
      S_SI: c_we = 1'b1;
      S_P0: q_raddr = j[5:0];
      S_P1: c_rd = 1'b1;
      S_P2: begin
        rsel = j;
        csel = b;
        c_rd = 1'b1;
      end
      S_P3: begin
        rsel = j;
        c_rd = 1'b1;
      end
      S_P4: begin
        csel = b;
        c_rd = 1'b1;
      end
      S_U0: begin
        c_rd = 1'b1;
        case (op)
          2'd0: begin rsel = bi; csel = ba; end
          2'd1: begin rsel = bj; csel = bb; end
          2'd2: begin rsel = bj; csel = ba; end
          default: begin rsel = bi; csel = bb; end
        endcase
      end
      S_U1: begin
        c_we = 1'b1;
        if (!op[1]) begin
          r_wdata = r_rdata - 7'd1;
          f_wdata = f_rdata - 7'd1;
        end
      end
      S_W0: begin
        q_we = 1'b1;
        q_waddr = bi[5:0];
        q_wdata = bb;
      end
      S_W1: begin
        q_we = 1'b1;
        q_waddr = bj[5:0];
        q_wdata = ba;
      end
      default: ;
    endcase
  end

  // column memory
  always_ff @(posedge clk) begin
    if (q_we) qmem[q_waddr] <= q_wdata;
    q_rdata <= qmem[q_raddr];
  end

  // diagonal count memories
  always_ff @(posedge clk) begin
    if (c_we) begin
      rmem[r_waddr] <= r_wdata;
      fmem[f_waddr] <= f_wdata;
    end
    r_rdata <= rmem[r_raddr];
    f_rdata <= fmem[f_raddr];
    if (c_rd) begin
      r_addr_q <= r_raddr;
      f_addr_q <= f_raddr;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      board_size <= 7'd8;
    end else if (cfg_we) begin
      board_size <= cfg_data;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_set) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            out_data <= '0;
            case (in_data.req_type)
              qshc_pkg::REQ_START: begin
                n <= n_eff;
                h <= '0;
                steps <= '0;
                k <= '0;
                if (n_eff == 7'd0) state <= S_DONE;
                else state <= S_CLR;
              end
              qshc_pkg::REQ_READ: state <= S_READ;
              default: ;
            endcase
          end
        end
        S_READ: begin
          out_data.read_column <= q_rdata;
          state <= S_IDLE;
        end
        S_CLR: begin
          k <= k + 7'd1;
          if (k == LAST_DIAG) begin
            i <= '0;
            state <= S_SR;
          end
        end
        S_SR: state <= S_SC;
        S_SC: begin
          a <= sat;
          state <= S_SI;
        end
        S_SI: begin
          h <= h - $signed(rf_sum);
          if (i + 7'd1 < n) begin
            i <= i + 7'd1;
            state <= S_SR;
          end else if (n >= 7'd2) begin
            i <= '0;
            j <= 7'd1;
            found <= 1'b0;
            base <= h - $signed(rf_sum);
            state <= S_LA;
          end else begin
            state <= S_DONE;
          end
        end
        S_LA: state <= S_LB;
        S_LB: begin
          a <= q_rdata;
          state <= S_P0;
        end
        S_P0: state <= S_P1;
        S_P1: begin
          b <= q_rdata;
          delta <= -13'sd4
                   - (({1'b0, j} + {2'b0, a} == {1'b0, i} + {2'b0, q_rdata}) ? 13'sd2 : 13'sd0)
                   - (({1'b0, j} + {2'b0, q_rdata} == {1'b0, i} + {2'b0, a}) ? 13'sd2 : 13'sd0);
          state <= S_P2;
        end
        S_P2: begin
          delta <= delta + $signed(rf_sum);
          state <= S_P3;
        end
        S_P3: begin
          delta <= delta + $signed(rf_sum);
          state <= S_P4;
        end
        S_P4: begin
          delta <= delta - $signed(rf_sum);
          state <= S_P5;
        end
        S_P5: begin
          if (v > h) begin
            h <= v;
            found <= 1'b1;
            bi <= i;
            bj <= j;
            ba <= a;
            bb <= b;
          end
          if (j + 7'd1 < n) begin
            j <= j + 7'd1;
            state <= S_P0;
          end else if (i + 7'd2 < n) begin
            i <= i + 7'd1;
            j <= i + 7'd2;
            state <= S_LA;
          end else if (found || (v > h)) begin
            op <= '0;
            state <= S_U0;
          end else begin
            state <= S_DONE;
          end
        end
        S_U0: state <= S_U1;
        S_U1: begin
          op <= op + 2'd1;
          if (op == 2'd3) state <= S_W0;
          else state <= S_U0;
        end
        S_W0: state <= S_W1;
        S_W1: begin
          steps <= steps + 12'd1;
          found <= 1'b0;
          base <= h;
          i <= '0;
          j <= 7'd1;
          state <= S_LA;
        end
        S_DONE: begin
          out_data.conflicts <= 12'(-h);
          out_data.step_count <= steps;
          out_data.solved <= (h == 13'sd0);
          out_data.read_column <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ tb/qshc_checker.sv @@
`timescale 1ns / 1ps
module qshc_checker (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [6:0]          cfg_data,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire qshc_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire qshc_pkg::out_item_t out_data,
  output int                       fail_count,
  output int                       pending
);

  logic [6:0]          size_reg;
  logic [5:0]          cols [qshc_pkg::MAX_SIZE];
  int                  rise_cnt [qshc_pkg::DIAGS];
  int                  fall_cnt [qshc_pkg::DIAGS];
  qshc_pkg::out_item_t expected_q [$];

  // score of the board after swapping the columns of rows i and j
  function automatic int swap_gain(int n, int i, int j, int base);
    int a, b, v;
    a = cols[i];
    b = cols[j];
    v = base;
    v += rise_cnt[n-1+i-a] - 1;
    v += fall_cnt[i+a] - 1;
    v += rise_cnt[n-1+j-b] - 1;
    if (j - b == i - a) v--;
    v += fall_cnt[j+b] - 1;
    if (j + b == i + a) v--;
    v -= rise_cnt[n-1+j-a];
    v -= fall_cnt[j+a];
    v -= rise_cnt[n-1+i-b];
    if (i - b == j - a) v--;
    v -= fall_cnt[i+b];
    if (i + b == j + a) v--;
    return v;
  endfunction

  // full climb on the held board, returns the start result
  function automatic qshc_pkg::out_item_t climb(int n);
    qshc_pkg::out_item_t r;
    int h, base, bi, bj, a, b, p, q;
    logic [11:0] steps;
    r = '0;
    h = 0;
    steps = '0;
    for (int k = 0; k < qshc_pkg::DIAGS; k++) begin
      rise_cnt[k] = 0;
      fall_cnt[k] = 0;
    end
    if (n > 0) begin
      for (int i = 0; i < n; i++) begin
        if (cols[i] > n - 1) cols[i] = 6'(n - 1);
        rise_cnt[n-1+i-cols[i]]++;
        fall_cnt[i+cols[i]]++;
      end
      for (int k = 0; k < 2*n-1; k++) begin
        p = rise_cnt[k];
        q = fall_cnt[k];
        h -= (p*(p-1))/2 + (q*(q-1))/2;
      end
      forever begin
        base = h;
        bi = -1;
        bj = 0;
        for (int i = 0; i < n; i++)
          for (int j = i + 1; j < n; j++) begin
            p = swap_gain(n, i, j, base);
            if (p > h) begin
              h = p;
              bi = i;
              bj = j;
            end
          end
        if (bi < 0) break;
        a = cols[bi];
        b = cols[bj];
        rise_cnt[n-1+bi-a]--; fall_cnt[bi+a]--;
        rise_cnt[n-1+bj-b]--; fall_cnt[bj+b]--;
        rise_cnt[n-1+bj-a]++; fall_cnt[bj+a]++;
        rise_cnt[n-1+bi-b]++; fall_cnt[bi+b]++;
        cols[bi] = 6'(b);
        cols[bj] = 6'(a);
        steps++;
      end
    end
    r.conflicts  = 12'(-h);
    r.step_count = steps;
    r.solved     = (h == 0);
    return r;
  endfunction

  // expected result of one request
  function automatic qshc_pkg::out_item_t predict_result(qshc_pkg::in_item_t it);
    qshc_pkg::out_item_t r;
    int n;
    r = '0;
    n = (size_reg > qshc_pkg::MAX_SIZE) ? qshc_pkg::MAX_SIZE : size_reg;
    case (it.req_type)
      qshc_pkg::REQ_LOAD: begin
        cols[it.row_index] = it.column_value;
      end
      qshc_pkg::REQ_START: begin
        r = climb(n);
      end
      qshc_pkg::REQ_READ: begin
        r.read_column = cols[it.row_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  // watch config, input and output channels
  always @(posedge clk) begin
    qshc_pkg::out_item_t e;
    if (rst) begin
      size_reg <= 7'd8;
      for (int k = 0; k < qshc_pkg::MAX_SIZE; k++) cols[k] = '0;
      expected_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== out_data) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(predict_result(in_data));
      if (cfg_we) size_reg <= cfg_data;
      pending <= expected_q.size();
    end
  end

endmodule

@@ tb/tb_queens_swap_hill_climber.sv @@
`timescale 1ns / 1ps
module tb_queens_swap_hill_climber;

  localparam int IDLE_LIMIT = 100000000;
  localparam int ITEM_GOAL  = 900;
  localparam logic [1:0] REQ_OTHER = 2'd3;

  logic      clk = 0;
  logic      rst = 1;
  logic      cfg_we = 0;
  logic [6:0] cfg_data = '0;
  logic      in_valid = 0;
  logic      in_stall;
  qshc_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  qshc_pkg::out_item_t out_data;
  int        fail_count, pending;
  int        idle_cycles = 0;
  int        items_sent = 0;
  int        big_boards = 0;
  bit        no_gaps = 0;
  bit        written [qshc_pkg::MAX_SIZE];

  always #2 clk = ~clk;

  queens_swap_hill_climber dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  qshc_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // mostly short gaps, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output stall pattern
  always @(posedge clk) begin
    if (rst || no_gaps) out_stall <= 0;
    else out_stall <= (gap_len() != 0);
  end

  // watchdog on cycles without any accepted input or output item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] req, logic [5:0] row, logic [5:0] col);
    int g;
    in_valid <= 1;
    in_data  <= '{req_type: req, row_index: row, column_value: col};
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (req == qshc_pkg::REQ_LOAD) written[row] = 1;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic set_size(logic [6:0] v);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we   <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic read_random();
    int r;
    do r = $urandom_range(0, qshc_pkg::MAX_SIZE - 1); while (!written[r]);
    send_item(qshc_pkg::REQ_READ, 6'(r), 6'($urandom));
  endtask

  // one board: load all rows, mixed traffic, climb, read back
  task automatic run_board(int n, int extra);
    int perm [qshc_pkg::MAX_SIZE];
    int t, s, op;
    bit as_perm;
    as_perm = ($urandom_range(0, 9) < 7);
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      s = $urandom_range(0, i);
      t = perm[i]; perm[i] = perm[s]; perm[s] = t;
    end
    for (int i = 0; i < n; i++)
      send_item(qshc_pkg::REQ_LOAD, 6'(i), as_perm ? 6'(perm[i]) : 6'($urandom));
    for (int k = 0; k < extra; k++) begin
      op = $urandom_range(0, 9);
      if (op < 3) send_item(qshc_pkg::REQ_LOAD, 6'($urandom), 6'($urandom));
      else if (op < 8) read_random();
      else send_item(REQ_OTHER, 6'($urandom), 6'($urandom));
    end
    send_item(qshc_pkg::REQ_START, 6'($urandom), 6'($urandom));
    for (int i = 0; i < n && i < 4; i++) read_random();
    if ($urandom_range(0, 4) == 0)
      send_item(qshc_pkg::REQ_START, 6'($urandom), 6'($urandom));
  endtask

  initial begin
    int sz, n;
    int directed_sizes [8];
    directed_sizes = '{4, 0, 1, 2, 3, 127, 5, 6};
    for (int k = 0; k < qshc_pkg::MAX_SIZE; k++) written[k] = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset size, unknown request, extremes of columns and rows
    send_item(REQ_OTHER, 6'h3f, 6'h3f);
    send_item(qshc_pkg::REQ_LOAD, 6'd63, 6'd63);
    send_item(qshc_pkg::REQ_READ, 6'd63, 6'd0);
    for (int i = 0; i < 8; i++)
      send_item(qshc_pkg::REQ_LOAD, 6'(i), (i == 3) ? 6'd63 : 6'(i));
    send_item(qshc_pkg::REQ_START, 6'd0, 6'd0);
    send_item(qshc_pkg::REQ_READ, 6'd3, 6'd0);
    send_item(qshc_pkg::REQ_START, 6'd0, 6'd0);
    foreach (directed_sizes[d]) begin
      set_size(7'(directed_sizes[d]));
      n = directed_sizes[d] > qshc_pkg::MAX_SIZE ? qshc_pkg::MAX_SIZE : directed_sizes[d];
      if (n == qshc_pkg::MAX_SIZE) big_boards++;
      run_board(n, 1);
    end

    // random boards, mostly small
    while (items_sent < ITEM_GOAL) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      t_pick: begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) sz = $urandom_range(4, 10);
        else if (r < 96) sz = $urandom_range(0, 16);
        else if (big_boards < 2) begin
          sz = $urandom_range(64, 127);
          big_boards++;
        end else sz = $urandom_range(11, 20);
      end
      set_size(7'(sz));
      n = sz > qshc_pkg::MAX_SIZE ? qshc_pkg::MAX_SIZE : sz;
      run_board(n, $urandom_range(2, 12));
    end
    no_gaps = 0;

    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
